@@ rtl/gkg_pkg.sv @@
`default_nettype none

package gkg_pkg;

   localparam int NUM_STAGES = 20;
   localparam int EXP_STAGES = 14;
   localparam int SQUARINGS  = 8;

   // ceil(2^33 / 3): exact reciprocal for x/6 (shift 34) and x/24 (shift 36), x < 2^31
   localparam logic [31:0] RECIP_THIRD = 32'd2863311531;

   localparam logic [63:0] EXP_LIMIT = 64'd12 << 32;
   localparam logic [31:0] ONE_Q31   = 32'h8000_0000;

   typedef logic [1:0]            csr_index_type;
   typedef logic [EXP_STAGES-1:0] exp_en_type;

   localparam csr_index_type CSR_DIMENSION = 2'd0;
   localparam csr_index_type CSR_HALF_INV  = 2'd1;
   localparam csr_index_type CSR_INV_CUBE  = 2'd2;

endpackage

`default_nettype wire

@@ rtl/gkg_exp.sv @@
`default_nettype none

module gkg_exp
   import gkg_pkg::*;
(
   input  wire logic        clock,
   input  wire exp_en_type  en,
   input  wire logic [63:0] t,
   output logic [16:0]      k
);

   logic [30:0] x_s4_ff, x_s5_ff, x_s6_ff, x_s7_ff;
   logic [30:0] x2_s4_ff, x2_s5_ff, x2_s6_ff, x2_s7_ff;
   logic [30:0] x3_s5_ff, x4_s6_ff;
   logic [30:0] d6_s6_ff, d6_s7_ff, d24_s7_ff;
   logic [31:0] y_ff;
   logic [31:0] sq_ff [SQUARINGS];
   logic        z_ff  [SQUARINGS+5];
   logic [16:0] k_ff;

   logic [30:0] x_in;
   logic [61:0] x2_full, x3_full, x4_full;
   logic [62:0] d6_full, d24_full;
   logic [31:0] y_in;
   logic [32:0] k_sum;
   logic [63:0] sq_prod [SQUARINGS];

   assign x_in     = t[39:9];
   assign x2_full  = 62'(x_in) * 62'(x_in);
   assign x3_full  = 62'(x2_s4_ff) * 62'(x_s4_ff);
   assign x4_full  = 62'(x3_s5_ff) * 62'(x_s5_ff);
   assign d6_full  = 63'(x3_s5_ff) * 63'(RECIP_THIRD);
   assign d24_full = 63'(x4_s6_ff) * 63'(RECIP_THIRD);
   assign y_in     = ONE_Q31 - 32'(x_s7_ff) + 32'(x2_s7_ff >> 1) - 32'(d6_s7_ff)
                     + 32'(d24_s7_ff);
   assign k_sum    = 33'(sq_ff[SQUARINGS-1]) + 33'd16384;

   always_comb begin
      sq_prod[0] = 64'(y_ff) * 64'(y_ff) + 64'd1073741824;
      for (int i = 1; i < SQUARINGS; i++) begin
         sq_prod[i] = 64'(sq_ff[i-1]) * 64'(sq_ff[i-1]) + 64'd1073741824;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_s4_ff  <= x_in;
         x2_s4_ff <= x2_full[61:31];
         z_ff[0]  <= (t >= EXP_LIMIT);
      end
      if (en[1]) begin
         x_s5_ff  <= x_s4_ff;
         x2_s5_ff <= x2_s4_ff;
         x3_s5_ff <= x3_full[61:31];
         z_ff[1]  <= z_ff[0];
      end
      if (en[2]) begin
         x_s6_ff  <= x_s5_ff;
         x2_s6_ff <= x2_s5_ff;
         x4_s6_ff <= x4_full[61:31];
         d6_s6_ff <= d6_full[61:31] >> 3;
         z_ff[2]  <= z_ff[1];
      end
      if (en[3]) begin
         x_s7_ff   <= x_s6_ff;
         x2_s7_ff  <= x2_s6_ff;
         d6_s7_ff  <= d6_s6_ff;
         d24_s7_ff <= d24_full[61:31] >> 5;
         z_ff[3]   <= z_ff[2];
      end
      if (en[4]) begin
         y_ff    <= y_in;
         z_ff[4] <= z_ff[3];
      end
      for (int i = 0; i < SQUARINGS; i++) begin
         if (en[5+i]) begin
            sq_ff[i]  <= sq_prod[i][62:31];
            z_ff[5+i] <= z_ff[4+i];
         end
      end
      if (en[EXP_STAGES-1]) begin
         k_ff <= z_ff[SQUARINGS+4] ? 17'd0 : k_sum[31:15];
      end
   end

   assign k = k_ff;

endmodule

`default_nettype wire

@@ rtl/gaussian_kernel_and_gradient_unit.sv @@
`default_nettype none

// Gaussian RBF kernel and length-scale gradient, one point pair per request.
// Request channel (req_*): two points of 1..3 signed Q16.16 coordinates and a
// last-pair marker, taken when req_valid and req_ready are both high.
// Response channel (rsp_*): kernel in unsigned Q1.16, gradient in unsigned
// Q16.16 (saturating) and the marker, delivered when rsp_valid and rsp_ready.
// CSR port: write-only; index 0 dimension, 1 half inverse squared length,
// 2 inverse cubed length. Write only while no request is in flight.
// rsp_valid rises once a taken request reaches the last of the 20 pipeline
// stages; one request per cycle is sustained while rsp_ready stays high, as
// every stage of the pipeline then takes new data.
// Each stage holds its data while the stage after it is full and stalled, so
// a stalled receiver backs the pipeline up stage by stage; empty stages still
// fill, and req_ready falls only once every stage is occupied.
// Synchronous reset empties the pipeline and restores the CSR defaults
// (dimension 3, half inverse 0.5, inverse cube 1.0).
module gaussian_kernel_and_gradient_unit
   import gkg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_first_x,
   input  wire logic [31:0] req_first_y,
   input  wire logic [31:0] req_first_z,
   input  wire logic [31:0] req_second_x,
   input  wire logic [31:0] req_second_y,
   input  wire logic [31:0] req_second_z,
   input  wire logic        req_last_pair,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [16:0]      rsp_kernel_value,
   output logic [31:0]      rsp_grad_value,
   output logic             rsp_last_pair_out,
   input  wire logic        csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0] csr_write_data
);

   function automatic logic [48:0] sq_diff(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] d;
      logic [32:0] m;
      logic [65:0] p;
      d = {a[31], a} - {b[31], b};
      m = d[32] ? (~d + 33'd1) : d;
      p = 66'(m) * 66'(m);
      return p[64:16];
   endfunction

   logic [1:0]  dimension_ff;
   logic [31:0] half_inv_ff;
   logic [31:0] inv_cube_ff;

   logic [NUM_STAGES:1]   valid_ff;
   logic [NUM_STAGES+1:1] en;
   logic [NUM_STAGES:1]   last_ff;

   logic [48:0] sqx_ff, sqy_ff, sqz_ff;
   logic [31:0] d2_ff [17:2];
   logic [63:0] t_ff;
   logic [16:0] k_exp;
   logic [16:0] k18_ff, k19_ff, k20_ff;
   logic [32:0] p_ff;
   logic [64:0] prod_ff;
   logic [31:0] g_ff;

   logic        use_y, use_z;
   logic [49:0] sum_in;
   logic [48:0] p_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= 2'd3;
         half_inv_ff  <= 32'd32768;
         inv_cube_ff  <= 32'd65536;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DIMENSION: dimension_ff <= csr_write_data[1:0];
            CSR_HALF_INV:  half_inv_ff  <= csr_write_data;
            CSR_INV_CUBE:  inv_cube_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      en[NUM_STAGES+1] = rsp_ready;
      for (int i = NUM_STAGES; i >= 1; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int i = 2; i <= NUM_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign use_y  = (dimension_ff == 2'd2) || (dimension_ff == 2'd3);
   assign use_z  = (dimension_ff == 2'd3);
   assign sum_in = 50'(sqx_ff) + 50'(sqy_ff) + 50'(sqz_ff);
   assign p_full = 49'(d2_ff[17]) * 49'(k_exp);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         last_ff[1] <= req_last_pair;
         sqx_ff     <= sq_diff(req_first_x, req_second_x);
         sqy_ff     <= use_y ? sq_diff(req_first_y, req_second_y) : 49'd0;
         sqz_ff     <= use_z ? sq_diff(req_first_z, req_second_z) : 49'd0;
      end
      for (int i = 2; i <= NUM_STAGES; i++) begin
         if (en[i]) begin
            last_ff[i] <= last_ff[i-1];
         end
      end
      if (en[2]) begin
         d2_ff[2] <= (sum_in[49:32] != 18'd0) ? 32'hFFFF_FFFF : sum_in[31:0];
      end
      for (int i = 3; i <= 17; i++) begin
         if (en[i]) begin
            d2_ff[i] <= d2_ff[i-1];
         end
      end
      if (en[3]) begin
         t_ff <= 64'(d2_ff[2]) * 64'(half_inv_ff);
      end
      if (en[18]) begin
         p_ff   <= p_full[48:16];
         k18_ff <= k_exp;
      end
      if (en[19]) begin
         prod_ff <= 65'(p_ff) * 65'(inv_cube_ff);
         k19_ff  <= k18_ff;
      end
      if (en[20]) begin
         g_ff   <= (prod_ff[64:48] != 17'd0) ? 32'hFFFF_FFFF : prod_ff[47:16];
         k20_ff <= k19_ff;
      end
   end

   gkg_exp u_exp (
      .clock (clock),
      .en    (en[17:4]),
      .t     (t_ff),
      .k     (k_exp)
   );

   assign req_ready         = en[1];
   assign rsp_valid         = valid_ff[NUM_STAGES];
   assign rsp_kernel_value  = k20_ff;
   assign rsp_grad_value    = g_ff;
   assign rsp_last_pair_out = last_ff[NUM_STAGES];

   a_kernel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kernel_value <= 17'd65536))
      else $error("kernel above one");

   a_zero_kernel_grad: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kernel_value == 17'd0) |-> (rsp_grad_value == 32'd0))
      else $error("gradient without kernel");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response after reset");

endmodule

`default_nettype wire

@@ tb/sv/tb_gaussian_kernel_and_gradient_unit.sv @@
`timescale 1ns / 1ps

module tb_gaussian_kernel_and_gradient_unit;
   import gkg_pkg::*;

   typedef struct {
      logic [31:0] first_x, first_y, first_z;
      logic [31:0] second_x, second_y, second_z;
      logic        last_pair;
   } point_pair_type;

   typedef struct {
      logic [16:0] kernel_value;
      logic [31:0] grad_value;
      logic        last_pair_out;
   } kernel_grad_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_first_x = '0, req_first_y = '0, req_first_z = '0;
   logic [31:0] req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic        req_last_pair = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [16:0] rsp_kernel_value;
   logic [31:0] rsp_grad_value;
   logic        rsp_last_pair_out;
   logic        csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_DIMENSION;
   logic [31:0] csr_write_data = '0;

   // predictor copy of the registers
   logic [1:0]  dim_reg = 2'd3;
   logic [31:0] half_inv_reg = 32'd32768;
   logic [31:0] inv_cube_reg = 32'd65536;

   point_pair_type  pending_q[$];
   kernel_grad_type kernel_expect_q[$];
   point_pair_type  in_flight;
   int  error_count = 0;
   int  send_gap = 0;
   int  recv_stall = 0;
   int  quiet_cycles = 0;
   bit  bursts_on = 1'b1;

   gaussian_kernel_and_gradient_unit DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] trunc_sq_diff(logic [31:0] a, logic [31:0] b);
      logic signed [32:0] d;
      logic [32:0] m;
      logic [65:0] sq;
      d  = $signed({a[31], a}) - $signed({b[31], b});
      m  = d[32] ? -d : d;
      sq = m * m;
      return 64'(sq >> 16);
   endfunction

   function automatic kernel_grad_type predict_kernel(point_pair_type p);
      kernel_grad_type r;
      logic [63:0] d2, t, x, x2, x3, x4, y, prod;
      logic [127:0] gw;
      d2 = trunc_sq_diff(p.first_x, p.second_x);
      if (dim_reg >= 2) d2 += trunc_sq_diff(p.first_y, p.second_y);
      if (dim_reg >= 3) d2 += trunc_sq_diff(p.first_z, p.second_z);
      if (d2 > 64'hFFFF_FFFF) d2 = 64'hFFFF_FFFF;
      t = d2 * {32'd0, half_inv_reg};
      if (t >= EXP_LIMIT) begin
         r.kernel_value = '0;
      end else begin
         x  = t >> 9;
         x2 = (x * x) >> 31;
         x3 = (x2 * x) >> 31;
         x4 = (x3 * x) >> 31;
         y  = {32'd0, ONE_Q31} - x + x2 / 2 - x3 / 6 + x4 / 24;
         for (int i = 0; i < SQUARINGS; i++)
            y = (y * y + (64'd1 << 30)) >> 31;
         r.kernel_value = 17'((y + (64'd1 << 14)) >> 15);
      end
      prod = (d2 * {47'd0, r.kernel_value}) >> 16;
      gw = ({64'd0, prod} * {96'd0, inv_cube_reg}) >> 16;
      r.grad_value = (gw > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : gw[31:0];
      r.last_pair_out = p.last_pair;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            kernel_expect_q.push_back(predict_kernel(in_flight));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               in_flight = pending_q.pop_front();
               req_first_x   <= in_flight.first_x;
               req_first_y   <= in_flight.first_y;
               req_first_z   <= in_flight.first_z;
               req_second_x  <= in_flight.second_x;
               req_second_y  <= in_flight.second_y;
               req_second_z  <= in_flight.second_z;
               req_last_pair <= in_flight.last_pair;
               req_valid     <= 1'b1;
               if (bursts_on && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      kernel_grad_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (kernel_expect_q.size() == 0) begin
               report_mismatch("unexpected response", 32'(rsp_kernel_value), 32'd0);
            end else begin
               want = kernel_expect_q.pop_front();
               if (rsp_kernel_value !== want.kernel_value)
                  report_mismatch("kernel", 32'(rsp_kernel_value), 32'(want.kernel_value));
               if (rsp_grad_value !== want.grad_value)
                  report_mismatch("grad", rsp_grad_value, want.grad_value);
               if (rsp_last_pair_out !== want.last_pair_out)
                  report_mismatch("last_pair", 32'(rsp_last_pair_out),
                                  32'(want.last_pair_out));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[gaussian_kernel_and_gradient_unit] ERROR");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_DIMENSION: dim_reg = value[1:0];
         CSR_HALF_INV:  half_inv_reg = value;
         CSR_INV_CUBE:  inv_cube_reg = value;
         default: ;
      endcase
   endtask

   task automatic push_pair(logic [31:0] fx, fy, fz, sx, sy, sz, logic last);
      point_pair_type p;
      p.first_x = fx; p.first_y = fy; p.first_z = fz;
      p.second_x = sx; p.second_y = sy; p.second_z = sz;
      p.last_pair = last;
      pending_q.push_back(p);
   endtask

   // mostly near pairs so the kernel is not always zero; some fully random
   function automatic logic [31:0] near_coord(logic [31:0] base);
      if ($urandom_range(0, 4) == 0)
         return $urandom;
      return base + ($urandom >> $urandom_range(8, 31)) * ($urandom_range(0, 1) ? 1 : -1);
   endfunction

   task automatic push_random(int n);
      logic [31:0] fx, fy, fz;
      for (int i = 0; i < n; i++) begin
         fx = $urandom; fy = $urandom; fz = $urandom;
         push_pair(fx, fy, fz, near_coord(fx), near_coord(fy), near_coord(fz),
                   1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || kernel_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings
      push_pair('0, '0, '0, '0, '0, '0, 1'b0);
      push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      push_pair(32'h8000_0000, '0, '0, 32'h7FFF_FFFF, '0, '0, 1'b0);
      push_pair(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0, '0, '0, 1'b1);
      push_pair(32'hFFFF_FFFF, 32'h0000_0001, '0, 32'h0000_0001, 32'hFFFF_FFFF, '0, 1'b0);
      push_pair(32'h0004_0000, '0, '0, '0, '0, '0, 1'b0);
      push_pair('0, 32'h0000_8000, '0, '0, '0, 32'h0000_8000, 1'b1);
      wait_drained();

      // dimension zero, zero length coefficient; y and z must be ignored
      write_csr(CSR_DIMENSION, 32'd0);
      write_csr(CSR_HALF_INV, 32'd0);
      write_csr(CSR_INV_CUBE, 32'hFFFF_FFFF);
      push_pair(32'h0001_0000, 32'h1234_5678, 32'h7FFF_FFFF, '0, '0, 32'h8000_0000, 1'b1);
      push_pair(32'h7FFF_FFFF, '0, '0, 32'h8000_0000, 32'h5555_5555, '0, 1'b0);
      push_random(150);
      wait_drained();

      write_csr(CSR_DIMENSION, 32'd1);
      write_csr(CSR_HALF_INV, 32'hFFFF_FFFF);
      write_csr(CSR_INV_CUBE, 32'd0);
      push_random(150);
      wait_drained();

      write_csr(CSR_DIMENSION, 32'd2);
      write_csr(CSR_HALF_INV, 32'd1);
      write_csr(CSR_INV_CUBE, 32'hFFFF_FFFF);
      push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 32'h8000_0000, 32'h8000_0000, '0, 1'b1);
      push_random(150);
      wait_drained();

      write_csr(CSR_DIMENSION, 32'd3);
      write_csr(CSR_HALF_INV, 32'd32768);
      write_csr(CSR_INV_CUBE, 32'd65536);
      push_random(200);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         write_csr(CSR_DIMENSION, $urandom_range(0, 3));
         write_csr(CSR_HALF_INV, $urandom >> $urandom_range(0, 31));
         write_csr(CSR_INV_CUBE, $urandom >> $urandom_range(0, 31));
         push_random(180);
         wait_drained();
      end

      // closing stretch without idling on either side
      bursts_on = 1'b0;
      write_csr(CSR_DIMENSION, 32'd3);
      write_csr(CSR_HALF_INV, $urandom >> 12);
      write_csr(CSR_INV_CUBE, $urandom >> 8);
      push_random(150);
      wait_drained();

      if (error_count == 0)
         $display("[gaussian_kernel_and_gradient_unit] OK");
      else
         $display("[gaussian_kernel_and_gradient_unit] ERROR");
      $finish;
   end

endmodule
